FILE: rtl/rfc_pkg.sv
// Shared types and constants for the record frame checker.
package rfc_pkg;

   // Frame layout, in byte positions from the start of the frame
   localparam int HEADER_BYTES     = 4 + 2 + 4;
   localparam int BODY_FIXED_BYTES = 4 + 2;
   localparam int NAME_START       = HEADER_BYTES + BODY_FIXED_BYTES;
   localparam int MAGIC_END        = 4;
   localparam int VERSION_END      = 6;
   localparam int PAYLOAD_END      = 10;
   localparam int ID_END           = 14;

   // Register reset values ("LCPP" magic)
   localparam logic [31:0] MAGIC_RESET    = 32'h4C43_5050;
   localparam logic [15:0] VERSION_RESET  = 16'd1;
   localparam logic [15:0] MAX_NAME_RESET = 16'd1024;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MAGIC_WORD       = 2'd0,
      CSR_EXPECTED_VERSION = 2'd1,
      CSR_MAX_NAME_BYTES   = 2'd2
   } csr_index_type;

   // Frame status codes
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TRUNCATED   = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_BAD_LENGTH  = 3'd4,
      ST_TRAILING    = 3'd5
   } status_type;

   // Result kinds
   localparam logic KIND_NAME   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  name_char;
      logic [31:0] decoded_id;
      logic [15:0] decoded_name_length;
      logic [2:0]  status;
      logic        run_end;
   } rsp_type;

endpackage

FILE: rtl/record_frame_checker.sv
// Record frame checker: byte-serial header decode, name pass-through, final status.
// Results are written into the result queue when a request is accepted and leave through rsp_valid.
// Throughput: one byte per cycle while req_stall is low; a byte that yields a name
// result and a status writes both into the 4-entry result queue.
// req_stall rises while the queue holds three or more results.
// Reset (synchronous, active high) empties the queue, clears the frame state and
// loads the register defaults; csr_ready is always high.
module record_frame_checker
   import rfc_pkg::*;
#(
   parameter int COUNT_BITS = 33
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Registers
   logic [31:0]           magic_word_ff;
   logic [15:0]           expected_version_ff;
   logic [15:0]           max_name_bytes_ff;
   logic [COUNT_BITS-1:0] bytes_seen_ff,   bytes_seen_in;
   logic                  magic_ff,        magic_in;
   logic [15:0]           version_ff,      version_in;
   logic [31:0]           payload_ff,      payload_in;
   logic [31:0]           ident_ff,        ident_in;
   logic [15:0]           name_len_ff,     name_len_in;
   rsp_type               queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff,       wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff,       rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff,        count_in;

   // Combinational
   logic                  req_accept;
   logic                  rsp_accept;
   logic [COUNT_BITS-1:0] pos;
   logic [COUNT_BITS-1:0] frame_len;
   logic [COUNT_BITS-1:0] body_len;
   logic [4:0]            magic_shift;
   logic [7:0]            magic_want;
   logic                  magic_upd;
   logic [15:0]           version_upd;
   logic [31:0]           payload_upd;
   logic [31:0]           ident_upd;
   logic [15:0]           name_len_upd;
   logic                  name_hit;
   logic                  emit_status;
   status_type            status_code;
   logic [15:0]           name_len_fld;
   logic [31:0]           ident_fld;
   rsp_type               name_rsp;
   rsp_type               status_rsp;
   rsp_type               first_rsp;
   logic                  first_wr;
   logic                  second_wr;
   logic [RSP_PTR_W-1:0]  second_ptr;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > RSP_CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = queue_ff[rd_ptr_ff];
   assign csr_ready  = 1'b1;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff       <= MAGIC_RESET;
         expected_version_ff <= VERSION_RESET;
         max_name_bytes_ff   <= MAX_NAME_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAGIC_WORD:       magic_word_ff       <= csr_data;
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_data[15:0];
            CSR_MAX_NAME_BYTES:   max_name_bytes_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Header field assembly and name window decode
   always_comb begin
      pos          = bytes_seen_ff;
      magic_shift  = {~pos[1:0], 3'b000};
      magic_want   = magic_word_ff[magic_shift +: 8];
      magic_upd    = magic_ff;
      version_upd  = version_ff;
      payload_upd  = payload_ff;
      ident_upd    = ident_ff;
      name_len_upd = name_len_ff;
      name_hit     = 1'b0;
      if (pos < COUNT_BITS'(MAGIC_END)) begin
         if (req_data.data_byte != magic_want) begin
            magic_upd = 1'b0;
         end
      end else if (pos < COUNT_BITS'(VERSION_END)) begin
         version_upd = {version_ff[7:0], req_data.data_byte};
      end else if (pos < COUNT_BITS'(PAYLOAD_END)) begin
         payload_upd = {payload_ff[23:0], req_data.data_byte};
      end else if (pos < COUNT_BITS'(ID_END)) begin
         ident_upd = {ident_ff[23:0], req_data.data_byte};
      end else if (pos < COUNT_BITS'(NAME_START)) begin
         name_len_upd = {name_len_ff[7:0], req_data.data_byte};
      end else begin
         name_hit = (pos - COUNT_BITS'(NAME_START)) < COUNT_BITS'(name_len_ff);
      end
      // saturating byte count
      frame_len = (pos == COUNT_MAX) ? pos : pos + 1'b1;
   end

   // Final status, checked in precedence order on the updated fields
   always_comb begin
      body_len = frame_len - COUNT_BITS'(NAME_START);
      if (frame_len < COUNT_BITS'(HEADER_BYTES)) begin
         status_code = ST_TRUNCATED;
      end else if (!magic_upd) begin
         status_code = ST_BAD_MAGIC;
      end else if (version_upd != expected_version_ff) begin
         status_code = ST_BAD_VERSION;
      end else if (CMP_W'(payload_upd) !=
                   CMP_W'(frame_len - COUNT_BITS'(HEADER_BYTES))) begin
         status_code = ST_BAD_LENGTH;
      end else if (frame_len < COUNT_BITS'(NAME_START)) begin
         status_code = ST_TRUNCATED;
      end else if (name_len_upd > max_name_bytes_ff ||
                   COUNT_BITS'(name_len_upd) > body_len) begin
         status_code = ST_BAD_LENGTH;
      end else if (body_len != COUNT_BITS'(name_len_upd)) begin
         status_code = ST_TRAILING;
      end else begin
         status_code = ST_OK;
      end
   end

   // Result records and frame state next values
   always_comb begin
      emit_status  = req_data.final_byte;
      name_len_fld = name_len_upd;
      ident_fld    = ident_upd;

      name_rsp                     = '0;
      name_rsp.item_kind           = KIND_NAME;
      name_rsp.name_char           = req_data.data_byte;

      status_rsp                     = '0;
      status_rsp.item_kind           = KIND_STATUS;
      status_rsp.decoded_id          = ident_fld;
      status_rsp.decoded_name_length = name_len_fld;
      status_rsp.status              = status_code;
      status_rsp.run_end             = 1'b1;

      first_rsp  = name_hit ? name_rsp : status_rsp;
      first_wr   = req_accept && (name_hit || emit_status);
      second_wr  = req_accept && name_hit && emit_status;
      second_ptr = wr_ptr_ff + 1'b1;

      // frame state: advance, or clear after the final byte
      bytes_seen_in = frame_len;
      magic_in      = magic_upd;
      version_in    = version_upd;
      payload_in    = payload_upd;
      ident_in      = ident_upd;
      name_len_in   = name_len_upd;
      if (emit_status) begin
         bytes_seen_in = '0;
         magic_in      = 1'b1;
         version_in    = '0;
         payload_in    = '0;
         ident_in      = '0;
         name_len_in   = '0;
      end

      // queue pointers
      wr_ptr_in = wr_ptr_ff;
      if (second_wr) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(2);
      end else if (first_wr) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rsp_accept ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(first_wr) + RSP_CNT_W'(second_wr)
                  - RSP_CNT_W'(rsp_accept);
   end

   // Frame state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         magic_ff      <= 1'b1;
         version_ff    <= '0;
         payload_ff    <= '0;
         ident_ff      <= '0;
         name_len_ff   <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_accept) begin
            bytes_seen_ff <= bytes_seen_in;
            magic_ff      <= magic_in;
            version_ff    <= version_in;
            payload_ff    <= payload_in;
            ident_ff      <= ident_in;
            name_len_ff   <= name_len_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result queue storage
   always_ff @(posedge clock) begin
      if (first_wr) begin
         queue_ff[wr_ptr_ff] <= first_rsp;
      end
      if (second_wr) begin
         queue_ff[second_ptr] <= status_rsp;
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.final_byte |=> bytes_seen_ff == '0 && magic_ff)
      else $error("frame state not cleared after final byte");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_data.final_byte && bytes_seen_ff != COUNT_MAX
      |=> bytes_seen_ff == $past(bytes_seen_ff) + 1'b1)
      else $error("byte counter did not advance");

   a_name_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.item_kind == KIND_NAME
      |-> !rsp_data.run_end && rsp_data.status == ST_OK)
      else $error("name result carries status fields");

endmodule

FILE: tb/record_frame_checker_tb.sv
// Self-checking testbench for the record frame checker.
module record_frame_checker_tb
   import rfc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_W     = 33;
   localparam int PHASE_BYTES = 75;
   localparam logic [1:0] CSR_SPARE = 2'd3;   // unmapped register index

   // Ways a generated frame can deviate from a well-formed record
   typedef enum int {
      FLAW_NONE, FLAW_TRAILING, FLAW_MAGIC, FLAW_VERSION, FLAW_PAYLOAD,
      FLAW_SHORT, FLAW_NAME_LONG, FLAW_NAME_OVER, FLAW_NOISE
   } flaw_type;

   // Tracks frame state and register settings, predicts results and checks them
   class frame_scoreboard;
      logic [31:0]        magic_reg;
      logic [15:0]        version_reg;
      logic [15:0]        max_name_reg;
      logic [COUNT_W-1:0] frame_len;
      logic               magic_ok;
      logic [15:0]        version_seen;
      logic [31:0]        payload_seen;
      logic [31:0]        ident_seen;
      logic [15:0]        name_len;
      rsp_type            awaited_results[$];
      int                 mismatches;

      function new();
         magic_reg    = MAGIC_RESET;
         version_reg  = VERSION_RESET;
         max_name_reg = MAX_NAME_RESET;
         mismatches   = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_len    = '0;
         magic_ok     = 1'b1;
         version_seen = '0;
         payload_seen = '0;
         ident_seen   = '0;
         name_len     = '0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            CSR_MAGIC_WORD:       magic_reg    = value;
            CSR_EXPECTED_VERSION: version_reg  = value[15:0];
            CSR_MAX_NAME_BYTES:   max_name_reg = value[15:0];
            default: ;
         endcase
      endfunction

      // Status precedence at the end of a frame of len bytes
      function status_type frame_status(logic [COUNT_W-1:0] len);
         logic [COUNT_W-1:0] body;
         if (len < HEADER_BYTES) return ST_TRUNCATED;
         if (!magic_ok) return ST_BAD_MAGIC;
         if (version_seen != version_reg) return ST_BAD_VERSION;
         if (payload_seen != len - HEADER_BYTES) return ST_BAD_LENGTH;
         if (len < NAME_START) return ST_TRUNCATED;
         body = len - NAME_START;
         if (name_len > max_name_reg || name_len > body) return ST_BAD_LENGTH;
         if (body != name_len) return ST_TRAILING;
         return ST_OK;
      endfunction

      // One accepted request: update header fields, queue the results it causes
      function void take_byte(req_type req);
         rsp_type            r;
         logic [COUNT_W-1:0] p;
         logic [31:0]        shifted;
         p = frame_len;
         if (p < MAGIC_END) begin
            shifted = magic_reg >> (8 * (3 - int'(p)));
            if (req.data_byte != shifted[7:0]) magic_ok = 1'b0;
         end else if (p < VERSION_END) begin
            version_seen = {version_seen[7:0], req.data_byte};
         end else if (p < PAYLOAD_END) begin
            payload_seen = {payload_seen[23:0], req.data_byte};
         end else if (p < ID_END) begin
            ident_seen = {ident_seen[23:0], req.data_byte};
         end else if (p < NAME_START) begin
            name_len = {name_len[7:0], req.data_byte};
         end else if (p - NAME_START < name_len) begin
            r = '0;
            r.item_kind = KIND_NAME;
            r.name_char = req.data_byte;
            awaited_results = {awaited_results, r};
         end
         if (frame_len != {COUNT_W{1'b1}}) frame_len++;
         if (req.final_byte) begin
            r = '0;
            r.item_kind           = KIND_STATUS;
            r.decoded_id          = ident_seen;
            r.decoded_name_length = name_len;
            r.status              = frame_status(frame_len);
            r.run_end             = 1'b1;
            awaited_results = {awaited_results, r};
            clear_frame();
         end
      endfunction

      function string show(rsp_type r);
         return $sformatf("kind=%0d char=%02h id=%08h len=%0d status=%0d end=%0d",
                          r.item_kind, r.name_char, r.decoded_id,
                          r.decoded_name_length, r.status, r.run_end);
      endfunction

      function void count_fault(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            count_fault({"unexpected result: ", show(got)});
            return;
         end
         want = awaited_results.pop_front();
         if (got.item_kind !== want.item_kind || got.name_char !== want.name_char ||
             got.decoded_id !== want.decoded_id ||
             got.decoded_name_length !== want.decoded_name_length ||
             got.status !== want.status || got.run_end !== want.run_end)
            count_fault({"result mismatch: expected ", show(want), " got ", show(got)});
      endfunction

      function void check_leftover();
         foreach (awaited_results[i])
            count_fault({"missing result: ", show(awaited_results[i])});
         awaited_results.delete();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   frame_scoreboard sb = new();
   int bytes_sent = 0;
   bit steady = 1'b0;   // no request gaps for the current frame

   record_frame_checker #(
      .COUNT_BITS(COUNT_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Gap before a request: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Well-formed frames in 8 of 20 picks, the rest broken or plain noise
   function automatic flaw_type pick_flaw();
      int r;
      r = $urandom_range(0, 19);
      if (r < 8) return FLAW_NONE;
      if (r < 10) return FLAW_TRAILING;
      if (r == 10) return FLAW_MAGIC;
      if (r == 11) return FLAW_VERSION;
      if (r == 12) return FLAW_PAYLOAD;
      if (r < 15) return FLAW_SHORT;
      if (r == 15) return FLAW_NAME_LONG;
      if (r < 18) return FLAW_NAME_OVER;
      return FLAW_NOISE;
   endfunction

   // Offer one request, called at a falling edge; returns at a falling edge
   task automatic push_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.data_byte  = value;
      req_data.final_byte = last;
      do @(posedge clock); while (req_stall);
      sb.take_byte(req_data);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Build one frame from the current settings and send it; cut forces a short length
   task automatic send_frame(input flaw_type flaw, input int name_cap, input int cut);
      logic [7:0]  fb[$];
      logic [31:0] magic;
      logic [31:0] payload;
      logic [31:0] ident;
      logic [15:0] version;
      logic [15:0] nl;
      int          nlen;
      int          body_len;
      int          extra;
      int          stop;
      int          k;
      magic   = sb.magic_reg;
      version = sb.version_reg;
      ident   = $urandom;
      extra   = 0;
      nlen    = $urandom_range(0, name_cap);
      if (nlen > sb.max_name_reg) nlen = sb.max_name_reg;
      body_len = nlen;
      case (flaw)
         FLAW_TRAILING: extra = $urandom_range(1, 4);
         FLAW_NAME_LONG: begin
            if (sb.max_name_reg != 16'hFFFF) begin
               nlen = sb.max_name_reg + 1;
               if ($urandom_range(0, 1)) nlen += $urandom_range(0, 40);
               if (nlen > 65535) nlen = 65535;
               body_len = $urandom_range(0, 8);
            end
         end
         FLAW_NAME_OVER: begin
            nlen = $urandom_range(1, 12);
            body_len = $urandom_range(0, nlen - 1);
         end
         default: ;
      endcase
      payload = BODY_FIXED_BYTES + body_len + extra;
      if (flaw == FLAW_VERSION) version ^= 16'($urandom_range(1, 65535));
      if (flaw == FLAW_PAYLOAD)
         payload ^= $urandom_range(0, 1) ? 32'($urandom_range(1, 3)) : ($urandom | 32'h1);
      stop = NAME_START + body_len + extra;
      if (flaw == FLAW_SHORT) begin
         stop = (cut != 0) ? cut : $urandom_range(1, stop - 1);
         // header complete but body missing: make the size field agree
         if (stop >= HEADER_BYTES && stop < NAME_START) payload = stop - HEADER_BYTES;
      end
      nl = 16'(nlen);
      for (int i = 3; i >= 0; i--) fb = {fb, magic[8*i +: 8]};
      fb = {fb, version[15:8]};
      fb = {fb, version[7:0]};
      for (int i = 3; i >= 0; i--) fb = {fb, payload[8*i +: 8]};
      for (int i = 3; i >= 0; i--) fb = {fb, ident[8*i +: 8]};
      fb = {fb, nl[15:8]};
      fb = {fb, nl[7:0]};
      repeat (body_len + extra) fb = {fb, 8'($urandom)};
      if (flaw == FLAW_MAGIC) begin
         k = $urandom_range(0, 3);
         fb[k] ^= 8'(1 << $urandom_range(0, 7));
      end
      if (flaw == FLAW_SHORT) fb = fb[0:stop-1];
      if (flaw == FLAW_NOISE) begin
         fb.delete();
         repeat ($urandom_range(1, 40)) fb = {fb, 8'($urandom)};
      end
      steady = ($urandom_range(0, 3) == 0);
      foreach (fb[i]) push_byte(fb[i], i == fb.size() - 1);
   endtask

   // Register write; leaves csr_valid high for a following write
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [31:0] magic, input logic [31:0] version,
                               input logic [31:0] max_name);
      write_csr(CSR_MAGIC_WORD, magic);
      write_csr(CSR_EXPECTED_VERSION, version);
      write_csr(CSR_MAX_NAME_BYTES, max_name);
      csr_valid = 1'b0;
   endtask

   // Stop requests and wait until every predicted result has come back
   task automatic drain();
      req_valid = 1'b0;
      while (sb.awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Result side back-pressure: stretches of stall and of free flow
   initial begin
      int  left;
      logic hold;
      rsp_stall = 1'b0;
      left = 0;
      hold = 1'b0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            hold = !hold;
            if (hold)
               left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            else
               left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
         end
         rsp_stall = hold;
         left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int goal;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MAGIC_WORD;
      csr_data  = '0;
      reset     = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: one-byte frame, minimal good frame, header-only frame
      push_byte(8'hFF, 1'b1);
      send_frame(FLAW_NONE, 0, 0);
      send_frame(FLAW_SHORT, 0, HEADER_BYTES);

      // Random frames under several register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: program_regs(32'h0, 32'h0, 32'h0);
            2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
            3: begin
               program_regs($urandom, $urandom, {16'($urandom), 16'($urandom_range(0, 20))});
               write_csr(CSR_SPARE, $urandom);
               csr_valid = 1'b0;
            end
            4: program_regs($urandom, $urandom_range(0, 3), $urandom_range(21, 65535));
            5: program_regs(MAGIC_RESET, VERSION_RESET, MAX_NAME_RESET);
            default: ;
         endcase
         goal = bytes_sent + PHASE_BYTES;
         while (bytes_sent < goal) send_frame(pick_flaw(), 16, 0);
         drain();
      end

      repeat (10) @(posedge clock);
      sb.check_leftover();
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: record_frame_checker.f
rtl/rfc_pkg.sv
rtl/record_frame_checker.sv
tb/record_frame_checker_tb.sv
